// ===== hdl/b64se_pkg.sv =====
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
package b64se_pkg;

  // Input item: one raw byte and its end-of-message mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  // Result item: one ASCII character and its last-of-message mark
  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } out_item_t;

  // Group handed from front to back: 24 data bits, trailing pad count, last mark
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  pad;
    logic        last;
  } group_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Number of groups held between front and back (2 or more)
  localparam int GQ_DEPTH = 2;

  localparam logic [5:0] SEXTET_MASK = 6'h3F;
  localparam logic [6:0] PAD_CHAR    = 7'h3D;  // '='
  localparam logic [6:0] CHAR_UPPER  = 7'h41;  // 'A'
  localparam logic [6:0] CHAR_LOWER  = 7'h61;  // 'a'
  localparam logic [6:0] CHAR_DIGIT  = 7'h30;  // '0'
  localparam logic [6:0] CHAR_PLUS   = 7'h2B;  // '+'
  localparam logic [6:0] CHAR_SLASH  = 7'h2F;  // '/'

  // Pad counts of a group
  localparam logic [1:0] PAD_NONE = 2'd0;
  localparam logic [1:0] PAD_ONE  = 2'd1;
  localparam logic [1:0] PAD_TWO  = 2'd2;

  // Map a 6-bit value onto the standard alphabet
  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] v7;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      return CHAR_UPPER + v7;
    end else if (v < 6'd52) begin
      return CHAR_LOWER + (v7 - 7'd26);
    end else if (v < 6'd62) begin
      return CHAR_DIGIT + (v7 - 7'd52);
    end else if (v == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

endpackage

// ===== hdl/b64se_front.sv =====
// Front end: accepts bytes, gathers them into groups and queues closed groups.
module b64se_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  b64se_pkg::in_item_t      item,
  input  b64se_pkg::queue_status_t gq_status,
  output logic                     full,
  output logic                     gq_write,
  output b64se_pkg::group_t        gq_data
);

  logic [15:0] pending_bytes;
  logic [1:0]  pending_count;
  logic [15:0] pending_bytes_next;
  logic [1:0]  pending_count_next;
  logic        accept;

  // Stall the input whenever the group queue cannot take another group
  assign full   = gq_status.full;
  assign accept = push && !gq_status.full;

  // Classify the byte against the pending count
  always_comb begin
    pending_bytes_next = pending_bytes;
    pending_count_next = pending_count;
    gq_write           = 1'b0;
    gq_data.bits       = {pending_bytes, item.data_byte};
    gq_data.pad        = b64se_pkg::PAD_NONE;
    gq_data.last       = item.end_of_message;
    if (accept) begin
      case (pending_count)
        2'd0: begin
          if (item.end_of_message) begin
            gq_write     = 1'b1;
            gq_data.bits = {item.data_byte, 16'h0000};
            gq_data.pad  = b64se_pkg::PAD_TWO;
            gq_data.last = 1'b1;
          end else begin
            pending_bytes_next = {item.data_byte, 8'h00};
            pending_count_next = 2'd1;
          end
        end
        2'd1: begin
          if (item.end_of_message) begin
            gq_write           = 1'b1;
            gq_data.bits       = {pending_bytes[15:8], item.data_byte, 8'h00};
            gq_data.pad        = b64se_pkg::PAD_ONE;
            gq_data.last       = 1'b1;
            pending_bytes_next = 16'h0000;
            pending_count_next = 2'd0;
          end else begin
            pending_bytes_next = {pending_bytes[15:8], item.data_byte};
            pending_count_next = 2'd2;
          end
        end
        default: begin
          // third byte closes the group; a count of three behaves as two
          gq_write           = 1'b1;
          pending_bytes_next = 16'h0000;
          pending_count_next = 2'd0;
        end
      endcase
    end
  end

  // Hold the partial group
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bytes <= 16'h0000;
      pending_count <= 2'd0;
    end else begin
      pending_bytes <= pending_bytes_next;
      pending_count <= pending_count_next;
    end
  end

endmodule

// ===== hdl/b64se_group_fifo.sv =====
// Short queue of closed groups between the front and back ends.
module b64se_group_fifo (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     write,
  input  b64se_pkg::group_t        wr_data,
  input  logic                     read,
  output b64se_pkg::group_t        rd_data,
  output b64se_pkg::queue_status_t status
);

  localparam int PTR_W = $clog2(b64se_pkg::GQ_DEPTH);
  localparam int CNT_W = $clog2(b64se_pkg::GQ_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(b64se_pkg::GQ_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(b64se_pkg::GQ_DEPTH);

  b64se_pkg::group_t entries [b64se_pkg::GQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_write;
  logic              do_read;

  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign do_write     = write && !status.full;
  assign do_read      = read && !status.empty;
  assign rd_data      = entries[rd_ptr];

  // Store the incoming group
  always_ff @(posedge clk) begin
    if (do_write) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_write) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_read) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_write && !do_read) begin
        count <= count + 1'b1;
      end else if (do_read && !do_write) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/b64se_back.sv =====
// Back end: expands each queued group into four characters through an output register.
module b64se_back (
  input  logic                     clk,
  input  logic                     rst,
  input  b64se_pkg::group_t        gq_data,
  input  b64se_pkg::queue_status_t gq_status,
  output logic                     gq_read,
  input  logic                     pop,
  output logic                     empty,
  output b64se_pkg::out_item_t     result
);

  logic                 out_valid;
  b64se_pkg::out_item_t out_reg;
  b64se_pkg::out_item_t char_next;
  logic [1:0]           char_idx;
  logic [5:0]           sextet;
  logic [2:0]           pad_sum;
  logic                 load;

  assign empty  = !out_valid;
  assign result = out_reg;

  // Load a character when the output slot is free or being drained
  assign load    = !gq_status.empty && (!out_valid || pop);
  assign gq_read = load && (char_idx == 2'd3);

  // Select the slice for the current character, most significant first
  always_comb begin
    case (char_idx)
      2'd0:    sextet = gq_data.bits[23:18];
      2'd1:    sextet = gq_data.bits[17:12];
      2'd2:    sextet = gq_data.bits[11:6];
      default: sextet = gq_data.bits[5:0];
    endcase
  end

  // Replace trailing characters with padding
  assign pad_sum = {1'b0, char_idx} + {1'b0, gq_data.pad};

  always_comb begin
    char_next.out_char  = (pad_sum >= 3'd4) ? b64se_pkg::PAD_CHAR
                                            : b64se_pkg::b64_char(sextet & b64se_pkg::SEXTET_MASK);
    char_next.last_char = (char_idx == 2'd3) && gq_data.last;
  end

  // Hold the shown character and step through the group
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      char_idx  <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        char_idx  <= char_idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg <= char_next;
    end
  end

endmodule

// ===== hdl/base64_stream_encoder.sv =====
// Top level of the base64 stream encoder: front end, group queue and back end.
//
// Usage:
//   Input channel: present a byte and its end_of_message mark on item with push
//   high; the transfer takes place at a rising edge where full is low. Bytes
//   may arrive every cycle while full stays low.
//   Result channel: while empty is low, result holds the oldest character; it
//   is transferred at a rising edge where pop is high.
//   A byte that completes a group of three, or closes a message early, yields
//   four characters; the group is written into the group queue, and its
//   characters then pass through the output register, one per cycle while
//   pop stays high. Padding '=' fills the tail of a short final group, and
//   last_char marks the final character. The single output register gives
//   one character per cycle while pop stays high.
//   When the receiver stalls, characters wait in the output register, closed
//   groups wait in a two-entry queue, and full rises once that queue is full.
//   Reset (rst, synchronous) drops any partial group, queued groups and the
//   waiting character; empty goes high and full low.
module base64_stream_encoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  b64se_pkg::in_item_t  item,
  output logic                 empty,
  input  logic                 pop,
  output b64se_pkg::out_item_t result
);

  b64se_pkg::queue_status_t gq_status;
  b64se_pkg::group_t        gq_wr_data;
  b64se_pkg::group_t        gq_rd_data;
  logic                     gq_write;
  logic                     gq_read;

  b64se_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .gq_status (gq_status),
    .full      (full),
    .gq_write  (gq_write),
    .gq_data   (gq_wr_data)
  );

  b64se_group_fifo u_group_fifo (
    .clk     (clk),
    .rst     (rst),
    .write   (gq_write),
    .wr_data (gq_wr_data),
    .read    (gq_read),
    .rd_data (gq_rd_data),
    .status  (gq_status)
  );

  b64se_back u_back (
    .clk       (clk),
    .rst       (rst),
    .gq_data   (gq_rd_data),
    .gq_status (gq_status),
    .gq_read   (gq_read),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  // No character appears without a queued group behind it
  a_no_spurious_char: assert property (@(posedge clk) disable iff (rst)
    (empty && gq_status.empty) |=> empty)
    else $error("character shown with no queued group");

  // The input only stalls while groups are queued
  a_full_has_groups: assert property (@(posedge clk) disable iff (rst)
    full |-> !gq_status.empty)
    else $error("input stalled with an empty group queue");

  // A padding character that is not last is followed by the final padding character
  a_pad_tail: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && result.out_char == b64se_pkg::PAD_CHAR && !result.last_char)
      |=> (!empty && result.out_char == b64se_pkg::PAD_CHAR && result.last_char))
    else $error("padding not closed by a final padding character");

endmodule

// ===== tb/b64se_stream_checker.sv =====
`timescale 1ns / 100ps
// Checker for the base64 stream encoder: predicts and compares the characters.
module b64se_stream_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  b64se_pkg::in_item_t  item,
  input  logic                 empty,
  input  logic                 pop,
  input  b64se_pkg::out_item_t result,
  output int                   fail_count,
  output int                   chars_outstanding
);

  // Standard alphabet, 'A' in the top byte
  localparam logic [511:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Bytes of the group still filling; first byte in the upper half
  logic [15:0]          held_bytes;
  logic [1:0]           held_count;
  b64se_pkg::out_item_t due_chars[$];
  b64se_pkg::out_item_t want;
  int                   bad;

  // Split a 24-bit group into four characters, padding the tail
  task automatic emit_group(input logic [23:0] group, input logic [1:0] pad, input logic last);
    b64se_pkg::out_item_t ch;
    int                   sextet;
    for (int k = 0; k < 4; k++) begin
      sextet = int'(group[18 - 6 * k +: 6]);
      ch.out_char = ALPHABET[8 * (63 - sextet) +: 7];
      if (k >= 4 - int'(pad)) begin
        ch.out_char = b64se_pkg::PAD_CHAR;
      end
      ch.last_char = (k == 3) ? last : 1'b0;
      due_chars.push_back(ch);
    end
  endtask

  // Advance the group state by one byte; a count of three acts as two
  task automatic encode_byte(input b64se_pkg::in_item_t it);
    case (held_count)
      2'd0: begin
        if (it.end_of_message) begin
          emit_group({it.data_byte, 16'h0000}, b64se_pkg::PAD_TWO, 1'b1);
        end else begin
          held_bytes = {it.data_byte, 8'h00};
          held_count = 2'd1;
        end
      end
      2'd1: begin
        if (it.end_of_message) begin
          emit_group({held_bytes[15:8], it.data_byte, 8'h00}, b64se_pkg::PAD_ONE, 1'b1);
          held_bytes = '0;
          held_count = 2'd0;
        end else begin
          held_bytes[7:0] = it.data_byte;
          held_count = 2'd2;
        end
      end
      default: begin
        emit_group({held_bytes, it.data_byte}, b64se_pkg::PAD_NONE, it.end_of_message);
        held_bytes = '0;
        held_count = 2'd0;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_bytes = '0;
      held_count = 2'd0;
      due_chars.delete();
      fail_count <= 0;
      chars_outstanding <= 0;
    end else begin
      bad = 0;
      // compare the character transferred at this edge with the oldest one due
      if (pop && !empty) begin
        if (due_chars.size() == 0) begin
          bad++;
          $display("%0t: unexpected character: expected none, actual %h/%b",
                   $realtime, result.out_char, result.last_char);
        end else begin
          want = due_chars.pop_front();
          if (result.out_char !== want.out_char) begin
            bad++;
            $display("%0t: out_char: expected %h, actual %h",
                     $realtime, want.out_char, result.out_char);
          end
          if (result.last_char !== want.last_char) begin
            bad++;
            $display("%0t: last_char: expected %b, actual %b",
                     $realtime, want.last_char, result.last_char);
          end
        end
      end
      // predict from the byte transferred at this edge
      if (push && !full) begin
        encode_byte(item);
      end
      fail_count <= fail_count + bad;
      chars_outstanding <= due_chars.size();
    end
  end

endmodule

// ===== tb/base64_stream_encoder_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the base64 stream encoder: byte stimulus, receiver stalls and verdict.
module base64_stream_encoder_test;

  logic                 clk  = 1'b0;
  logic                 rst  = 1'b1;
  logic                 push = 1'b0;
  logic                 pop  = 1'b0;
  b64se_pkg::in_item_t  item = '0;
  logic                 full;
  logic                 empty;
  b64se_pkg::out_item_t result;
  int                   fail_count;
  int                   chars_outstanding;
  int                   send_gap_pct = 0;
  int                   stall_pct = 0;
  int                   bytes_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  base64_stream_encoder uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  b64se_stream_checker char_check (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .item              (item),
    .empty             (empty),
    .pop               (pop),
    .result            (result),
    .fail_count        (fail_count),
    .chars_outstanding (chars_outstanding)
  );

  // Stall the receiver at random
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offer one byte after a random gap; hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic eom);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= {b, eom};
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  // Send a message of random bytes, extremes favoured, end mark on the last
  task automatic send_message(input int len);
    logic [7:0] b;
    int         pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
      send_byte(b, i == len - 1);
    end
  endtask

  // Hold the sender until every predicted character has been transferred
  task automatic wait_for_drain();
    push <= 1'b0;
    do @(posedge clk); while (chars_outstanding != 0);
  endtask

  initial begin
    int len;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // single byte closing a message: two pads
    send_byte(8'hFF, 1'b1);
    // two bytes closing a message: one pad
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // full group with the end mark, all '+'
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    // full groups without the end mark, then a short tail
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h9A, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b1);
    wait_for_drain();

    // random messages under each idling pattern, draining between phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_gap_pct <= 0;
          stall_pct <= 0;
        end
        1: begin
          send_gap_pct <= 69;
          stall_pct <= 0;
        end
        2: begin
          send_gap_pct <= 0;
          stall_pct <= 69;
        end
        default: begin
          send_gap_pct <= 26;
          stall_pct <= 26;
        end
      endcase
      while (bytes_sent < 20 + 110 * (phase + 1)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
        send_message(len);
      end
      wait_for_drain();
    end

    // let any stray character show
    repeat (20) @(posedge clk);
    if (fail_count == 0 && chars_outstanding == 0) begin
      $display("base64_stream_encoder: match");
    end else begin
      $display("base64_stream_encoder: mismatch");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #2000000;
    $display("base64_stream_encoder: mismatch");
    $finish;
  end

endmodule
